[design/htbbp_pkg.sv]
// Shared types, command codes and defaults for the Huffman table and byte packer.
`default_nettype none

package htbbp_pkg;

    localparam int NUM_SYMBOLS_DEF   = 256;
    localparam int MAX_CODE_BITS_DEF = 16;
    localparam int BYTE_W            = 8;

    // request commands
    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_ENCODE = 2'd1;
    localparam logic [1:0] CMD_FLUSH  = 2'd2;
    localparam logic [1:0] CMD_CLEAR  = 2'd3;

    // result status
    localparam logic [1:0] ST_BYTE     = 2'd0;
    localparam logic [1:0] ST_LONG     = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    // packer operations
    localparam logic [1:0] PK_NONE   = 2'd0;
    localparam logic [1:0] PK_ENCODE = 2'd1;
    localparam logic [1:0] PK_FLUSH  = 2'd2;
    localparam logic [1:0] PK_CLEAR  = 2'd3;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] first_symbol;
        logic [7:0] second_symbol;
        logic [7:0] pixel_value;
    } htbbp_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] status;
    } htbbp_out_t;

    typedef struct packed {
        logic       fire;
        logic [1:0] op;
        logic [7:0] code_al;   // code left aligned in the byte
        logic [3:0] len;
    } pk_req_t;

    typedef struct packed {
        logic       emit;
        logic [7:0] data;
    } pk_rsp_t;

endpackage

`default_nettype wire

[design/htbbp_ram.sv]
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module htbbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                                  aclk,
    input  wire logic                                  wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                      wr_data,
    input  wire logic                                  rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read returns the old contents on a same-address write
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[design/htbbp_pack.sv]
// Byte packer: places codes MSB first, never splitting a code across bytes.
`default_nettype none

module htbbp_pack
    import htbbp_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire pk_req_t req,
    output pk_rsp_t      rsp
);

    logic [7:0] pack_byte_reg, pack_byte_next;
    logic [3:0] pack_fill_reg, pack_fill_next;
    logic [4:0] fill_sum;

    always_comb begin
        fill_sum       = {1'b0, pack_fill_reg} + {1'b0, req.len};
        pack_byte_next = pack_byte_reg;
        pack_fill_next = pack_fill_reg;
        rsp.emit       = 1'b0;
        rsp.data       = pack_byte_reg;
        case (req.op)
            PK_ENCODE: begin
                if (fill_sum <= 5'(BYTE_W)) begin
                    pack_byte_next = pack_byte_reg | (req.code_al >> pack_fill_reg);
                    pack_fill_next = fill_sum[3:0];
                end else begin
                    rsp.emit       = 1'b1;
                    pack_byte_next = req.code_al;
                    pack_fill_next = req.len;
                end
            end
            PK_FLUSH: begin
                rsp.emit       = (pack_fill_reg != 4'd0);
                pack_byte_next = 8'd0;
                pack_fill_next = 4'd0;
            end
            PK_CLEAR: begin
                pack_byte_next = 8'd0;
                pack_fill_next = 4'd0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pack_byte_reg <= 8'd0;
            pack_fill_reg <= 4'd0;
        end else if (req.fire) begin
            pack_byte_reg <= pack_byte_next;
            pack_fill_reg <= pack_fill_next;
        end
    end

endmodule

`default_nettype wire

[design/huffman_table_build_and_byte_pack.sv]
// Huffman code table builder and byte packer: top level.
//
// Requests enter on s_valid/s_ready with an htbbp_in_t payload; results leave on
// m_valid/m_ready with an htbbp_out_t payload. Merge pairs (load) build the table,
// root pair first; encode requests look a pixel up and pack its code MSB first.
// The table lives in one RAM (code and length per symbol) with registered reads;
// per-symbol present flags sit in flops and are cleared at once by reset or clear.
// Throughput: one encode, flush or clear request per cycle while no result waits
// on a stalled receiver. A load that updates the table writes two entries, first
// then second symbol, through the single RAM write port and holds the lookup stage
// meanwhile; an ignored or overflowing load writes nothing. A result is registered
// in the output register that drives m_valid. A write from the preceding request is
// forwarded into the lookup, so back to back requests on the same symbol see the
// newest entry. When the receiver stalls, the output register holds its result;
// requests that give no result keep flowing, and one that gives a result waits in
// the lookup stage, which drops s_ready.
// Reset (aresetn low, synchronous) empties the table, the packer and both stages;
// no memory sweep is needed.
`default_nettype none

module huffman_table_build_and_byte_pack
    import htbbp_pkg::*;
#(
    parameter int NUM_SYMBOLS   = NUM_SYMBOLS_DEF,
    parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire htbbp_in_t  s_payload,
    output logic            m_valid,
    input  wire logic       m_ready,
    output htbbp_out_t      m_payload
);

    localparam int SYM_W = $clog2(NUM_SYMBOLS);
    localparam int LEN_W = $clog2(MAX_CODE_BITS + 1);
    localparam int ENT_W = MAX_CODE_BITS + LEN_W;
    localparam logic [8:0] SYM_LIM = 9'(NUM_SYMBOLS);

    // lookup stage
    logic             s1_valid_reg, s1_valid_next;
    htbbp_in_t        s1_req_reg;
    logic             s1_phase_reg, s1_phase_next;
    logic [ENT_W-1:0] b_entry_reg, b_entry_next;
    logic             root_loaded_reg, root_loaded_next;
    logic [NUM_SYMBOLS-1:0] present_reg;

    // forwarding of the most recent table write
    logic             fwd_valid_reg;
    logic [SYM_W-1:0] fwd_addr_reg;
    logic [ENT_W-1:0] fwd_data_reg;

    // output register
    logic       m_valid_reg;
    htbbp_out_t m_payload_reg, m_payload_next;

    logic             accept;
    logic [SYM_W-1:0] rd_addr;
    logic [ENT_W-1:0] rd_data;
    logic             wr_en;
    logic [SYM_W-1:0] wr_addr;
    logic [ENT_W-1:0] wr_data;

    logic [SYM_W-1:0] a_idx, b_idx, p_idx, s1_addr;
    logic             a_ok, b_ok, p_ok;
    logic [ENT_W-1:0] ent;
    logic [MAX_CODE_BITS-1:0] ent_bits, ext_code;
    logic [LEN_W-1:0] ent_len, new_len;
    logic             has_result, s1_fire, s1_retire, go_phase2;
    logic             pres_clr, pres_set;
    logic [SYM_W-1:0] pres_idx;
    pk_req_t          pk_req;
    pk_rsp_t          pk_rsp;

    assign accept  = s_valid && s_ready;
    assign rd_addr = (s_payload.command == CMD_ENCODE) ? s_payload.pixel_value[SYM_W-1:0]
                                                       : s_payload.first_symbol[SYM_W-1:0];

    htbbp_ram #(
        .WIDTH (ENT_W),
        .DEPTH (NUM_SYMBOLS)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    htbbp_pack u_pack (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (pk_req),
        .rsp     (pk_rsp)
    );

    always_comb begin
        a_idx    = s1_req_reg.first_symbol[SYM_W-1:0];
        b_idx    = s1_req_reg.second_symbol[SYM_W-1:0];
        p_idx    = s1_req_reg.pixel_value[SYM_W-1:0];
        a_ok     = {1'b0, s1_req_reg.first_symbol} < SYM_LIM;
        b_ok     = {1'b0, s1_req_reg.second_symbol} < SYM_LIM;
        p_ok     = {1'b0, s1_req_reg.pixel_value} < SYM_LIM;
        s1_addr  = (s1_req_reg.command == CMD_ENCODE) ? p_idx : a_idx;
        ent      = (fwd_valid_reg && fwd_addr_reg == s1_addr) ? fwd_data_reg : rd_data;
        ent_bits = ent[ENT_W-1 -: MAX_CODE_BITS];
        ent_len  = ent[LEN_W-1:0];
        ext_code = {ent_bits[MAX_CODE_BITS-2:0], 1'b0};
        new_len  = ent_len + LEN_W'(1);

        has_result       = 1'b0;
        go_phase2        = 1'b0;
        wr_en            = 1'b0;
        wr_addr          = a_idx;
        wr_data          = {ext_code, new_len};
        b_entry_next     = b_entry_reg;
        root_loaded_next = root_loaded_reg;
        pres_clr         = 1'b0;
        pres_set         = 1'b0;
        pres_idx         = a_idx;
        m_payload_next   = '{out_byte: 8'd0, status: ST_BYTE};
        pk_req           = '{fire: 1'b0, op: PK_NONE,
                             code_al: ent_bits[7:0] << (4'(BYTE_W) - ent_len[3:0]),
                             len: ent_len[3:0]};

        if (s1_valid_reg) begin
            case (s1_req_reg.command)
                CMD_LOAD: begin
                    if (s1_phase_reg) begin
                        wr_en    = 1'b1;
                        wr_addr  = b_idx;
                        wr_data  = b_entry_reg;
                        pres_set = 1'b1;
                        pres_idx = b_idx;
                    end else if (a_ok && b_ok) begin
                        if (!root_loaded_reg) begin
                            wr_en            = 1'b1;
                            wr_data          = {MAX_CODE_BITS'(0), LEN_W'(1)};
                            b_entry_next     = {MAX_CODE_BITS'(1), LEN_W'(1)};
                            root_loaded_next = 1'b1;
                            pres_set         = 1'b1;
                            go_phase2        = 1'b1;
                        end else if (present_reg[a_idx]) begin
                            if (ent_len >= LEN_W'(MAX_CODE_BITS)) begin
                                has_result     = 1'b1;
                                m_payload_next = '{out_byte: 8'd0, status: ST_OVERFLOW};
                            end else begin
                                wr_en        = 1'b1;
                                b_entry_next = {ext_code | MAX_CODE_BITS'(1), new_len};
                                go_phase2    = 1'b1;
                            end
                        end
                    end
                end
                CMD_ENCODE: begin
                    if (p_ok && present_reg[p_idx]) begin
                        if (ent_len > LEN_W'(BYTE_W)) begin
                            has_result     = 1'b1;
                            m_payload_next = '{out_byte: 8'd0, status: ST_LONG};
                        end else begin
                            pk_req.op = PK_ENCODE;
                        end
                    end
                end
                CMD_FLUSH: begin
                    pk_req.op = PK_FLUSH;
                end
                default: begin
                    pk_req.op        = PK_CLEAR;
                    root_loaded_next = 1'b0;
                    pres_clr         = 1'b1;
                end
            endcase
            if (pk_rsp.emit) begin
                has_result     = 1'b1;
                m_payload_next = '{out_byte: pk_rsp.data, status: ST_BYTE};
            end
        end

        s1_fire     = s1_valid_reg && !(has_result && m_valid_reg && !m_ready);
        s1_retire   = s1_fire && !go_phase2;
        pk_req.fire = s1_fire;
        s_ready     = !s1_valid_reg || s1_retire;

        // table writes never coincide with a stalled result
        wr_en    = wr_en && s1_fire;
        pres_set = pres_set && s1_fire;
        pres_clr = pres_clr && s1_fire;

        s1_valid_next = s1_valid_reg;
        s1_phase_next = s1_phase_reg;
        if (accept) begin
            s1_valid_next = 1'b1;
            s1_phase_next = 1'b0;
        end else if (s1_retire) begin
            s1_valid_next = 1'b0;
            s1_phase_next = 1'b0;
        end else if (s1_fire && go_phase2) begin
            s1_phase_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg    <= 1'b0;
            s1_phase_reg    <= 1'b0;
            root_loaded_reg <= 1'b0;
            present_reg     <= '0;
            fwd_valid_reg   <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            s1_phase_reg <= s1_phase_next;
            if (s1_fire) begin
                root_loaded_reg <= root_loaded_next;
            end
            if (pres_clr) begin
                present_reg <= '0;
            end else if (pres_set) begin
                present_reg[pres_idx] <= 1'b1;
            end
            if (wr_en) begin
                fwd_valid_reg <= 1'b1;
            end
            if (s1_fire && has_result) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_req_reg <= s_payload;
        end
        if (s1_fire && go_phase2) begin
            b_entry_reg <= b_entry_next;
        end
        if (wr_en) begin
            fwd_addr_reg <= wr_addr;
            fwd_data_reg <= wr_data;
        end
        if (s1_fire && has_result) begin
            m_payload_reg <= m_payload_next;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

endmodule

`default_nettype wire

[design/htbbp_checker.sv]
// Port-level checks for the Huffman table builder and byte packer, with bind.
`default_nettype none

module htbbp_checker
    import htbbp_pkg::*;
(
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire htbbp_out_t m_payload
);

    // a result waiting on the receiver stays put
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    a_hold_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_payload))
        else $error("result changed while stalled");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_payload.status == ST_BYTE || m_payload.status == ST_LONG ||
                     m_payload.status == ST_OVERFLOW))
        else $error("undefined status code");

    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.status != ST_BYTE |-> m_payload.out_byte == 8'd0)
        else $error("error result carries data");

    // a request passes the lookup stage before its result is registered, so nothing shows just after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid ##1 !m_valid)
        else $error("result shown straight after reset");

endmodule

bind huffman_table_build_and_byte_pack htbbp_checker u_htbbp_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_payload (m_payload)
);

`default_nettype wire

[sim/testbench.sv]
// Testbench for the Huffman table builder and byte packer: random and directed requests, scoreboarded.
`default_nettype none

module testbench
    import htbbp_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    class packed_byte_tracker;
        bit [15:0]   code_val [256];
        int unsigned code_len [256];
        bit          coded    [256];
        bit          have_root;
        bit [7:0]    acc_byte;
        int unsigned acc_fill;
        htbbp_out_t  bytes_due [$];
        int unsigned mismatches;
        int unsigned cmd_count [4];
        int unsigned status_count [3];

        function void wipe();
            foreach (coded[i]) begin
                coded[i]    = 1'b0;
                code_val[i] = '0;
                code_len[i] = 0;
            end
            have_root = 1'b0;
            acc_byte  = '0;
            acc_fill  = 0;
        endfunction

        function void owe(bit [7:0] value, logic [1:0] st);
            htbbp_out_t o;
            o.out_byte = value;
            o.status   = st;
            bytes_due.push_back(o);
        endfunction

        function int unsigned sent();
            return cmd_count[0] + cmd_count[1] + cmd_count[2] + cmd_count[3];
        endfunction

        // Updates the table and packer for one accepted request.
        function void take_request(htbbp_in_t r);
            int unsigned a, b, p, len;
            bit [15:0]   c;
            a     = r.first_symbol;
            b     = r.second_symbol;
            p     = r.pixel_value;
            cmd_count[r.command]++;
            case (r.command)
                CMD_LOAD: begin
                    if (!have_root) begin
                        code_val[a] = 16'd0;
                        code_len[a] = 1;
                        coded[a]    = 1'b1;
                        code_val[b] = 16'd1;
                        code_len[b] = 1;
                        coded[b]    = 1'b1;
                        have_root   = 1'b1;
                    end else if (coded[a]) begin
                        len   = code_len[a];
                        if (len + 1 > MAX_CODE_BITS_DEF) begin
                            owe(8'h00, ST_OVERFLOW);
                        end else begin
                            c           = code_val[a] << 1;
                            code_val[a] = c;
                            code_len[a] = len + 1;
                            code_val[b] = c | 16'd1;
                            code_len[b] = len + 1;
                            coded[b]    = 1'b1;
                        end
                    end
                end
                CMD_ENCODE: begin
                    if (coded[p]) begin
                        len   = code_len[p];
                        if (len > 8) begin
                            owe(8'h00, ST_LONG);
                        end else begin
                            c = code_val[p] & ((16'd1 << len) - 16'd1);
                            if (acc_fill + len <= 8) begin
                                acc_byte = acc_byte | 8'(c << (8 - acc_fill - len));
                                acc_fill = acc_fill + len;
                            end else begin
                                // code does not fit: ship the padded byte, start afresh
                                owe(acc_byte, ST_BYTE);
                                acc_byte = 8'(c << (8 - len));
                                acc_fill = len;
                            end
                        end
                    end
                end
                CMD_FLUSH: begin
                    if (acc_fill != 0) begin
                        owe(acc_byte, ST_BYTE);
                        acc_byte = '0;
                        acc_fill = 0;
                    end
                end
                CMD_CLEAR: begin
                    wipe();
                end
            endcase
        endfunction

        task flag_mismatch(string what);
            $display("MISMATCH at %0t: %s", $time, what);
            mismatches++;
        endtask

        task take_result(htbbp_out_t got);
            htbbp_out_t want;
            if (bytes_due.size() == 0) begin
                flag_mismatch($sformatf("unexpected result byte %02h status %0d",
                                        got.out_byte, got.status));
                return;
            end
            want = bytes_due.pop_front();
            if (want.status < 3)
                status_count[want.status]++;
            if (got.status !== want.status)
                flag_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
            if (got.out_byte !== want.out_byte)
                flag_mismatch($sformatf("byte %02h, expected %02h (status %0d)",
                                        got.out_byte, want.out_byte, want.status));
        endtask

        // Random symbol that currently has a code no longer than the given length.
        function int pick_coded(int unsigned longest);
            int picks [$];
            foreach (coded[i])
                if (coded[i] && code_len[i] <= longest)
                    picks.push_back(i);
            if (picks.size() == 0)
                return -1;
            return picks[$urandom_range(0, picks.size() - 1)];
        endfunction
    endclass

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    htbbp_in_t  s_payload;
    logic       m_valid;
    logic       m_ready;
    htbbp_out_t m_payload;

    bit calm;
    bit hold_off;

    packed_byte_tracker book = new();

    huffman_table_build_and_byte_pack u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin : watchdog
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function int any8();
        return $urandom_range(0, 255);
    endfunction

    task automatic send_request(input htbbp_in_t r);
        if (!calm && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= r;
        do @(posedge aclk); while (!s_ready);
        book.take_request(r);
    endtask

    task automatic put(input logic [1:0] cmd, input int a, input int b, input int p);
        htbbp_in_t r;
        r.command       = cmd;
        r.first_symbol  = 8'(a);
        r.second_symbol = 8'(b);
        r.pixel_value   = 8'(p);
        send_request(r);
    endtask

    task automatic directed_part();
        int k;
        put(CMD_ENCODE, any8(), any8(), 0);      // empty table: pixel unknown
        put(CMD_FLUSH, any8(), any8(), any8());  // nothing packed yet
        put(CMD_LOAD, 5, 5, any8());             // root pair naming one symbol twice
        put(CMD_LOAD, 200, 7, any8());           // first symbol has no code
        put(CMD_LOAD, 5, 5, any8());             // later pair, same symbol twice
        put(CMD_ENCODE, any8(), any8(), 5);
        put(CMD_ENCODE, any8(), any8(), 255);
        put(CMD_FLUSH, any8(), any8(), any8());
        put(CMD_CLEAR, any8(), any8(), any8());
        put(CMD_LOAD, 0, 255, any8());
        // eight one-bit codes fill the byte exactly; it is held
        for (k = 0; k < 8; k++)
            put(CMD_ENCODE, any8(), any8(), (k % 2) ? 255 : 0);
        put(CMD_LOAD, 255, 128, any8());
        put(CMD_LOAD, 0, 255, any8());           // recodes an already coded symbol
        put(CMD_ENCODE, any8(), any8(), 128);
        put(CMD_ENCODE, any8(), any8(), 255);
        put(CMD_FLUSH, any8(), any8(), any8());
    endtask

    // One symbol grown step by step, into long codes and, with enough steps, past the table limit.
    task automatic deep_chain(input int steps);
        int s, p;
        put(CMD_CLEAR, any8(), any8(), any8());
        s = any8();
        put(CMD_LOAD, s, any8(), any8());
        repeat (steps) begin
            p = any8();
            put(CMD_LOAD, s, p, any8());
            if ($urandom_range(0, 3) == 0 && book.coded[p])
                s = p;
        end
        repeat ($urandom_range(6, 20)) begin
            p = book.pick_coded(16);
            if (p < 0 || $urandom_range(0, 3) == 0)
                p = any8();
            put(CMD_ENCODE, any8(), any8(), p);
        end
        put(CMD_FLUSH, any8(), any8(), any8());
    endtask

    task automatic noise_burst();
        repeat ($urandom_range(5, 15))
            put(2'($urandom_range(0, 3)), any8(), any8(), any8());
    endtask

    task automatic normal_epoch(input bit squeeze);
        int a, p, pick, n;
        if (!book.have_root || $urandom_range(0, 4) != 0) begin
            put(CMD_CLEAR, any8(), any8(), any8());
            put(CMD_LOAD, any8(), any8(), any8());
        end
        repeat ($urandom_range(1, 20)) begin
            a = book.pick_coded(7);
            if (a < 0 || $urandom_range(0, 19) == 0)
                a = any8();
            put(CMD_LOAD, a, any8(), any8());
        end
        // the sink goes quiet for a long while; requests keep coming
        if (squeeze)
            hold_off = 1'b1;
        n = squeeze ? 80 : $urandom_range(10, 60);
        repeat (n) begin
            pick = $urandom_range(0, 99);
            if (pick < 82) begin
                p = book.pick_coded(8);
                put(CMD_ENCODE, any8(), any8(), (p < 0) ? any8() : p);
            end else if (pick < 90) begin
                put(CMD_ENCODE, any8(), any8(), any8());
            end else if (pick < 93) begin
                p = book.pick_coded(16);
                put(CMD_ENCODE, any8(), any8(), (p < 0) ? any8() : p);
            end else if (pick < 97) begin
                put(CMD_FLUSH, any8(), any8(), any8());
            end else begin
                put(CMD_LOAD, any8(), any8(), any8());
            end
        end
        if ($urandom_range(0, 1) == 1)
            put(CMD_FLUSH, any8(), any8(), any8());
    endtask

    task automatic random_part();
        int  kind;
        bit  deep_done, squeezed;
        deep_done = 1'b0;
        squeezed  = 1'b0;
        while (book.sent() < 430) begin
            if (book.sent() >= 390)
                calm = 1'b1;
            kind = $urandom_range(0, 99);
            if (!deep_done) begin
                deep_chain(18);
                deep_done = 1'b1;
            end else if (!squeezed && book.sent() > 150) begin
                normal_epoch(1'b1);
                squeezed = 1'b1;
            end else if (kind < 15) begin
                deep_chain($urandom_range(8, 18));
            end else if (kind < 30) begin
                noise_burst();
            end else begin
                normal_epoch(1'b0);
            end
        end
    endtask

    initial begin : result_sink
        int unsigned gap;
        gap = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready)
                book.take_result(m_payload);
            if (hold_off) begin
                hold_off = 1'b0;
                gap      = 400;
            end else if (gap == 0 && !calm && $urandom_range(0, 9) == 0) begin
                gap = $urandom_range(1, 17);
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                gap--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_payload <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        directed_part();
        random_part();
        s_valid <= 1'b0;
        while (book.bytes_due.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
        $display("Covered %0d requests: %0d loads, %0d encodes, %0d flushes, %0d clears",
                 book.sent(),
                 book.cmd_count[CMD_LOAD], book.cmd_count[CMD_ENCODE],
                 book.cmd_count[CMD_FLUSH], book.cmd_count[CMD_CLEAR]);
        $display("Checked %0d packed bytes, %0d long-code drops, %0d table overflows",
                 book.status_count[ST_BYTE], book.status_count[ST_LONG],
                 book.status_count[ST_OVERFLOW]);
        if (book.mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
